FILE: src/cdf53_pkg.sv
// Shared types, constants and arithmetic helpers of the CDF 5/3 row transform.
`default_nettype none

package cdf53_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = 11;
  localparam int CFG_BITS    = 13;
  localparam logic [CFG_BITS-1:0] ROW_WIDTH_RESET = 13'd4096;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // What a queued column pair still has to deliver.
  typedef enum logic [1:0] {
    KIND_PAIR       = 2'd0,  // lowpass and highpass inside the row
    KIND_PAIR_END   = 2'd1,  // lowpass and highpass that close an even-width row
    KIND_PAIR_EXTRA = 2'd2   // pair plus a trailing lowpass that closes an odd-width row
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 row_first;  // first pair of its row: previous highpass is zero
    logic [POS_BITS-1:0]  pos;
    sample_t              even;
    sample_t              odd;
    sample_t              nxt;        // next even sample, also the base of the extra lowpass
  } entry_t;

  // Halve a sample with truncation toward zero.
  function automatic sample_t half_trunc(sample_t s);
    logic [SAMPLE_BITS:0] t;
    t = {s[SAMPLE_BITS-1], s} + {{SAMPLE_BITS{1'b0}}, s[SAMPLE_BITS-1]};
    return sample_t'(t[SAMPLE_BITS:1]);
  endfunction

  // Quarter a sample with truncation toward zero.
  function automatic sample_t quarter_trunc(sample_t s);
    logic [SAMPLE_BITS:0] t;
    t = {s[SAMPLE_BITS-1], s} + (s[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(3) : '0);
    return sample_t'({t[SAMPLE_BITS], t[SAMPLE_BITS:2]});
  endfunction

  // Predict step: odd - (even + next_even) / 2, wrapped.
  function automatic sample_t predict(sample_t odd, sample_t even, sample_t nxt);
    sample_t s;
    s = sample_t'(even + nxt);
    return sample_t'(odd - half_trunc(s));
  endfunction

  // Update step: base + (a + b) / 4, wrapped.
  function automatic sample_t update(sample_t base, sample_t a, sample_t b);
    sample_t s;
    s = sample_t'(a + b);
    return sample_t'(base + quarter_trunc(s));
  endfunction

endpackage

`default_nettype wire

FILE: src/cdf53_front.sv
// Front end: takes samples, tracks the column, and queues each completed column pair.
`default_nettype none

module cdf53_front
  import cdf53_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire sample_t             sample,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic                q_full,
  output logic                     q_push,
  output entry_t                   q_entry
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  logic [CFG_BITS-1:0] row_width_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  sample_t             held_even_r, held_odd_r;

  logic [31:0] w_eff, c_in, c_eff, k_full;
  logic        accept, is_even, row_end, has_result;

  assign cfg_ready = 1'b1;
  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    if (row_width_r < CFG_BITS'(2)) begin
      w_eff = 32'd2;
    end else if (32'(row_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(row_width_r);
    end
    c_in  = 32'(cnt_r);
    // A width shrunk below the current column starts a fresh row.
    c_eff = (c_in >= w_eff) ? 32'd0 : c_in;
    is_even = ~c_eff[0];
    row_end = (c_eff == w_eff - 32'd1);
    k_full  = is_even ? ((c_eff >> 1) - 32'd1) : (c_eff >> 1);
    has_result = is_even ? (c_eff >= 32'd2) : row_end;
    cnt_nxt = row_end ? '0 : CW'(c_eff + 32'd1);

    q_entry.pos       = k_full[POS_BITS-1:0];
    q_entry.row_first = (k_full == 32'd0);
    q_entry.even      = held_even_r;
    q_entry.odd       = is_even ? held_odd_r : sample;
    q_entry.nxt       = is_even ? sample : held_even_r;
    if (is_even) begin
      q_entry.kind = row_end ? KIND_PAIR_EXTRA : KIND_PAIR;
    end else begin
      q_entry.kind = KIND_PAIR_END;
    end
  end

  assign q_push = accept & has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
      cnt_r       <= '0;
      held_even_r <= '0;
      held_odd_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width_r <= cfg_data;
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
        if (is_even) begin
          held_even_r <= sample;
        end else begin
          held_odd_r <= sample;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_end) |=> (cnt_r == '0))
    else $error("column count did not return to zero after a row end");
`endif

endmodule

`default_nettype wire

FILE: src/cdf53_queue.sv
// Short queue of column pairs between the front end and the back end.
`default_nettype none

module cdf53_queue
  import cdf53_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  entry_t               mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;

  assign full       = (count_r == QCNT_BITS'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [QPTR_BITS-1:0] bump(logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: src/cdf53_back.sv
// Back end: lifts each queued pair, sending one result per cycle unless the output stalls.
`default_nettype none

module cdf53_back
  import cdf53_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  wire entry_t       q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output sample_t           coefficient,
  output logic              band,
  output logic [POS_BITS-1:0] position,
  output logic              last_of_run,
  output logic              row_done
);

  typedef enum logic [2:0] {
    PH_LOW   = 3'b001,
    PH_HIGH  = 3'b010,
    PH_EXTRA = 3'b100
  } phase_t;

  phase_t  phase_r;
  logic    busy_r;
  entry_t  ent_r;
  sample_t hp_r, prev_hp_r;

  logic                out_valid_r;
  sample_t             coef_r, coef_nxt;
  logic                band_r, band_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                last_r, last_nxt;
  logic                done_r, done_nxt;

  logic    out_free, emit, final_phase, load;
  sample_t up_base, up_a, up_b, prev_sel;

  assign out_free    = ~out_valid_r | out_tready;
  assign emit        = busy_r & out_free;
  assign final_phase = (ent_r.kind == KIND_PAIR_EXTRA) ? (phase_r == PH_EXTRA)
                                                       : (phase_r == PH_HIGH);
  assign load        = q_valid & (~busy_r | (emit & final_phase));
  assign q_pop       = load;
  assign prev_sel    = ent_r.row_first ? '0 : prev_hp_r;

  always_comb begin
    up_base  = ent_r.even;
    up_a     = prev_sel;
    up_b     = hp_r;
    coef_nxt = '0;
    band_nxt = 1'b0;
    pos_nxt  = ent_r.pos;
    last_nxt = 1'b0;
    done_nxt = 1'b0;
    case (phase_r)
      PH_LOW: begin
        coef_nxt = update(up_base, up_a, up_b);
      end
      PH_HIGH: begin
        coef_nxt = hp_r;
        band_nxt = 1'b1;
        last_nxt = (ent_r.kind != KIND_PAIR_EXTRA);
        done_nxt = (ent_r.kind == KIND_PAIR_END);
      end
      PH_EXTRA: begin
        up_base  = ent_r.nxt;
        up_a     = hp_r;
        up_b     = '0;
        coef_nxt = update(up_base, up_a, up_b);
        pos_nxt  = POS_BITS'(ent_r.pos + 1'b1);
        last_nxt = 1'b1;
        done_nxt = 1'b1;
      end
      default: begin
        coef_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= q_head;
      hp_r  <= predict(q_head.odd, q_head.even, q_head.nxt);
    end
    if (emit) begin
      coef_r <= coef_nxt;
      band_r <= band_nxt;
      pos_r  <= pos_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_LOW;
      prev_hp_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (emit && phase_r == PH_HIGH) begin
        prev_hp_r <= hp_r;
      end
      if (load) begin
        busy_r  <= 1'b1;
        phase_r <= PH_LOW;
      end else if (emit && final_phase) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        phase_r <= (phase_r == PH_LOW) ? PH_HIGH : PH_EXTRA;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign coefficient = coef_r;
  assign band        = band_r;
  assign position    = pos_r;
  assign last_of_run = last_r;
  assign row_done    = done_r;

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("row end flagged on a result that does not close its sample");
  a_extra_only_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && phase_r == PH_EXTRA) |-> (ent_r.kind == KIND_PAIR_EXTRA))
    else $error("extra lowpass phase entered for a pair without one");
`endif

endmodule

`default_nettype wire

FILE: src/cdf53_row_forward_lifting.sv
// Top level of the forward CDF 5/3 lifting wavelet, horizontal pass over rows.
//
// Samples enter one per transfer on the in_ channel (in_tdata holds one signed
// 16-bit sample) and fill the rows in order; the row width comes from the cfg_
// channel, a 13-bit write that is always ready and is meant to be used while
// the block is idle. Widths below two act as two and widths above MAX_WIDTH act
// as MAX_WIDTH. Every even sample after the first closes a column pair and
// yields a lowpass and then a highpass coefficient; the last sample of a row
// closes the final pair, and for odd widths adds one more lowpass. Each result
// goes out as one transfer on the out_ channel, tagged with band, position,
// tlast on the final result of its sample and a row-done flag on the final
// coefficient of the row.
// Throughput is one sample and one result per cycle when nothing stalls: the front
// end takes a sample every cycle while its four-entry pair queue has room, the
// back end sends one result per cycle while the output is free, and the queue
// absorbs the extra result at the end of an odd row. A pair's first result
// passes the queue, the back end's pair register and the output register after
// the sample that closes the pair. When the receiver stalls, the output register
// holds its result, the queue fills and then in_tready falls. Reset empties the
// queue, clears the column and the held samples and sets the row width to 4096.
`default_nettype none

module cdf53_row_forward_lifting
  import cdf53_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] coefficient, [26:16] position, rest zero
  output logic [1:0]       out_tuser,  // [0] band, [1] row_done
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data    // row_width
);

  logic    q_full, q_push, q_pop, q_valid;
  entry_t  push_entry, q_head;
  sample_t coefficient;
  logic    band, last_of_run, row_done;
  logic [POS_BITS-1:0] position;

  // Front end: column tracking and pair classification.
  cdf53_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    (sample_t'(in_tdata)),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // Queue that lets the two ends stall independently.
  cdf53_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back end: predict and update steps, one result per cycle unless the output stalls.
  cdf53_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .coefficient (coefficient),
    .band        (band),
    .position    (position),
    .last_of_run (last_of_run),
    .row_done    (row_done)
  );

  assign out_tdata = {5'b0, position, coefficient};
  assign out_tuser = {row_done, band};
  assign out_tlast = last_of_run;

endmodule

`default_nettype wire
